### design/pgtbl_pkg.sv
`timescale 1ns / 1ps

package pgtbl_pkg;

   localparam int TABLE_COUNT = 256;
   localparam int ENTRY_W     = 52;
   localparam int VIRT_W      = 48;
   localparam int FLAGS_W     = 12;
   localparam int IDX_W       = 9;
   localparam int PAGE_SHIFT  = 12;
   localparam int TIDX_W      = $clog2(TABLE_COUNT);
   localparam int CNT_W       = $clog2(TABLE_COUNT + 1);
   localparam int ADDR_W      = TIDX_W + IDX_W;
   localparam int DEPTH       = TABLE_COUNT * (2 ** IDX_W);

   localparam logic [ENTRY_W-1:0] MASK_4K = {{(ENTRY_W-12){1'b1}}, 12'h000};
   localparam logic [ENTRY_W-1:0] MASK_2M = {{(ENTRY_W-21){1'b1}}, 21'h0};
   localparam logic [ENTRY_W-1:0] P_BIT   = ENTRY_W'(1);
   localparam logic [ENTRY_W-1:0] PW_BITS = ENTRY_W'(3);
   localparam logic [ENTRY_W-1:0] BIG_BIT = ENTRY_W'(128);
   localparam int                 BIG_POS = 7;

   typedef enum logic [1:0] {
      OP_MAP       = 2'd0,
      OP_UNMAP     = 2'd1,
      OP_TRANSLATE = 2'd2,
      OP_NONE      = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_EXHAUSTED  = 2'd1,
      ST_UNDER_HUGE = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [VIRT_W-1:0]  virt_addr;
      logic [ENTRY_W-1:0] phys_addr;
      logic [FLAGS_W-1:0] entry_flags;
      logic               huge_page;
   } req_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] translated_addr;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic               sub;
      logic [ENTRY_W-1:0] a;
      logic [ENTRY_W-1:0] b;
   } alu_op_type;

endpackage

### design/pgtbl_ram.sv
`timescale 1ns / 1ps

module pgtbl_ram import pgtbl_pkg::*; (
   input  logic               clock,
   input  logic               we,
   input  logic [ADDR_W-1:0]  addr,
   input  logic [ENTRY_W-1:0] wdata,
   output logic [ENTRY_W-1:0] rdata
);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

### design/pgtbl_alu.sv
`timescale 1ns / 1ps

module pgtbl_alu import pgtbl_pkg::*; (
   input  alu_op_type         op,
   output logic [ENTRY_W-1:0] sum
);

   always_comb begin
      if (op.sub) begin
         sum = op.a - op.b;
      end else begin
         sum = op.a + op.b;
      end
   end

endmodule

### design/four_level_page_table_manager_top.sv
`timescale 1ns / 1ps
// Each table level is read in S_READ and evaluated in S_EVAL; each new table is written in
// S_ALLOC and a map's leaf entry in S_LEAF, after which the response strobe comes.
// One request is handled at a time, over the single table memory port; busy drops
// with the response strobe, and a new request may be taken in that cycle. No receiver stall.
// Reset (synchronous): root-only pool, pool_base 0, then a clearing pass over all
// TABLE_COUNT * 512 entries (131072 at 256 tables) with busy high; csr writes are taken during the pass.

module four_level_page_table_manager_top import pgtbl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  req_type            req_data,
   output logic               busy,
   output logic               rsp_strobe,
   output rsp_type            rsp_data,
   input  logic               csr_we,
   input  logic [ENTRY_W-1:0] csr_wdata
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CLEAR = 6'b000010,
      S_READ  = 6'b000100,
      S_EVAL  = 6'b001000,
      S_ALLOC = 6'b010000,
      S_LEAF  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [1:0]         lvl_ff, lvl_in;
   logic [TIDX_W-1:0]  tab_ff, tab_in;
   logic [CNT_W-1:0]   nf_ff, nf_in;
   logic [ENTRY_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;

   logic [IDX_W-1:0]   idx;
   logic [ADDR_W-1:0]  mem_addr;
   logic               mem_we;
   logic [ENTRY_W-1:0] mem_wdata;
   logic [ENTRY_W-1:0] ent;
   alu_op_type         alu_op;
   logic [ENTRY_W-1:0] sum;
   logic               present;
   logic               big;
   logic               tbl_ok;
   logic [1:0]         leaf_lvl;
   logic [1:0]         lvl_next;
   logic [1:0]         missing;
   logic               exhaust;
   logic [ENTRY_W-1:0] leaf_ent;
   logic [ENTRY_W-1:0] flags_ext;

   pgtbl_ram u_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (ent)
   );

   pgtbl_alu u_alu (
      .op  (alu_op),
      .sum (sum)
   );

   always_comb begin
      case (lvl_ff)
         2'd0:    idx = req_ff.virt_addr[47:39];
         2'd1:    idx = req_ff.virt_addr[38:30];
         2'd2:    idx = req_ff.virt_addr[29:21];
         default: idx = req_ff.virt_addr[20:12];
      endcase
   end

   assign present   = ent[0];
   assign big       = ent[BIG_POS];
   assign leaf_lvl  = req_ff.huge_page ? 2'd2 : 2'd3;
   assign lvl_next  = lvl_ff + 2'd1;
   assign missing   = leaf_lvl - lvl_ff;
   assign exhaust   = ({1'b0, nf_ff} + (CNT_W+1)'(missing)) > (CNT_W+1)'(TABLE_COUNT);
   assign tbl_ok    = present &&
                      (sum[ENTRY_W-1:PAGE_SHIFT] <
                       (ENTRY_W-PAGE_SHIFT)'(nf_ff));
   assign flags_ext = ENTRY_W'(req_ff.entry_flags);
   assign leaf_ent  = req_ff.huge_page ?
                      ((req_ff.phys_addr & MASK_2M) | flags_ext | PW_BITS | BIG_BIT) :
                      ((req_ff.phys_addr & MASK_4K) | flags_ext | P_BIT);

   always_comb begin
      alu_op.sub = 1'b1;
      alu_op.a   = ent & MASK_4K;
      alu_op.b   = base_ff & MASK_4K;
      if (state_ff == S_ALLOC) begin
         alu_op.sub = 1'b0;
         alu_op.a   = base_ff & MASK_4K;
         alu_op.b   = {(ENTRY_W-PAGE_SHIFT)'(nf_ff), 12'h000};
      end else if (req_ff.opcode == OP_TRANSLATE && lvl_ff == 2'd3) begin
         alu_op.sub = 1'b0;
         alu_op.a   = ent & MASK_4K;
         alu_op.b   = ENTRY_W'(req_ff.virt_addr[11:0]);
      end else if (req_ff.opcode == OP_TRANSLATE && lvl_ff == 2'd2 && big) begin
         alu_op.sub = 1'b0;
         alu_op.a   = ent & MASK_2M;
         alu_op.b   = ENTRY_W'(req_ff.virt_addr[20:0]);
      end
   end

   assign mem_addr = (state_ff == S_CLEAR) ? clr_ff : {tab_ff, idx};

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      lvl_in        = lvl_ff;
      tab_in        = tab_ff;
      nf_in         = nf_ff;
      clr_in        = clr_ff;
      base_in       = csr_we ? csr_wdata : base_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_wdata     = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               lvl_in   = 2'd0;
               tab_in   = '0;
               state_in = S_READ;
            end
         end
         S_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            rsp_in.translated_addr = '0;
            rsp_in.status          = ST_OK;
            case (req_ff.opcode)
               OP_MAP: begin
                  if (lvl_ff == 2'd2 && big) begin
                     rsp_in.status = ST_UNDER_HUGE;
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else if (!present) begin
                     if (exhaust) begin
                        rsp_in.status = ST_EXHAUSTED;
                        rsp_strobe_in = 1'b1;
                        state_in      = S_IDLE;
                     end else begin
                        state_in = S_ALLOC;
                     end
                  end else if (!tbl_ok) begin
                     rsp_in.status = ST_EXHAUSTED;
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     tab_in   = sum[PAGE_SHIFT +: TIDX_W];
                     lvl_in   = lvl_next;
                     state_in = (lvl_next == leaf_lvl) ? S_LEAF : S_READ;
                  end
               end
               OP_UNMAP, OP_TRANSLATE: begin
                  if (lvl_ff == 2'd3 || (lvl_ff == 2'd2 && big)) begin
                     if (req_ff.opcode == OP_UNMAP) begin
                        mem_we = 1'b1;
                     end else if (lvl_ff == 2'd2 || present) begin
                        rsp_in.translated_addr = sum;
                     end
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else if (!tbl_ok) begin
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     tab_in   = sum[PAGE_SHIFT +: TIDX_W];
                     lvl_in   = lvl_next;
                     state_in = S_READ;
                  end
               end
               default: begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end
            endcase
         end
         S_ALLOC: begin
            mem_we    = 1'b1;
            mem_wdata = sum | PW_BITS;
            tab_in    = nf_ff[TIDX_W-1:0];
            nf_in     = nf_ff + CNT_W'(1);
            lvl_in    = lvl_next;
            state_in  = (lvl_next == leaf_lvl) ? S_LEAF : S_ALLOC;
         end
         S_LEAF: begin
            mem_we                 = 1'b1;
            mem_wdata              = leaf_ent;
            rsp_in.translated_addr = '0;
            rsp_in.status          = ST_OK;
            rsp_strobe_in          = 1'b1;
            state_in               = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         nf_ff         <= CNT_W'(1);
         base_ff       <= '0;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nf_ff         <= nf_in;
         base_ff       <= base_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      lvl_ff <= lvl_in;
      tab_ff <= tab_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

### design/pgtbl_checker.sv
`timescale 1ns / 1ps

module pgtbl_checker import pgtbl_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after request accept");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("response one cycle after accept");

   a_idle_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("busy during response strobe");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe repeated");

   a_error_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != ST_OK) |-> (rsp_data.translated_addr == '0))
      else $error("address returned with error status");

endmodule

bind four_level_page_table_manager_top pgtbl_checker u_pgtbl_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

### tb/four_level_page_table_manager_top_tb.sv
`timescale 1ns / 1ps

module four_level_page_table_manager_top_tb;
   import pgtbl_pkg::*;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               start     = 1'b0;
   req_type            req_data  = '0;
   logic               busy;
   logic               rsp_strobe;
   rsp_type            rsp_data;
   logic               csr_we    = 1'b0;
   logic [ENTRY_W-1:0] csr_wdata = '0;

   four_level_page_table_manager_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // shadow of the table pool, indexed by table * 512 + entry; absent entries read as zero
   logic [ENTRY_W-1:0] table_image [int];
   int                 tables_handed_out = 1;
   logic [ENTRY_W-1:0] pool_base_shadow  = '0;

   rsp_type            pending_rsp [$];
   rsp_type            oldest_rsp;
   logic [VIRT_W-1:0]  mapped_virt [$];
   logic [IDX_W-1:0]   top_pick [2];
   logic [IDX_W-1:0]   mid_pick [2];
   logic [IDX_W-1:0]   dir_pick [4];
   int                 mismatches = 0;
   int                 rsp_count  = 0;

   localparam logic [VIRT_W-1:0]  VA_LOW  = '0;
   localparam logic [VIRT_W-1:0]  VA_HIGH = '1;
   localparam logic [VIRT_W-1:0]  VA_HUGE = 48'h0000_4020_0000;
   localparam logic [ENTRY_W-1:0] PA_HIGH = '1;

   function automatic int level_index(logic [VIRT_W-1:0] v, int l);
      return int'((v >> (PAGE_SHIFT + IDX_W * (3 - l))) & 48'h1FF);
   endfunction

   function automatic int slot_of(int tbl, int idx);
      return (tbl << IDX_W) + idx;
   endfunction

   function automatic logic [ENTRY_W-1:0] entry_at(int slot);
      if (table_image.exists(slot))
         return table_image[slot];
      return '0;
   endfunction

   // 1: table found, 0: entry not present, -1: pointer outside the handed-out pool
   function automatic int follow_pointer(logic [ENTRY_W-1:0] e, output int tbl);
      logic [ENTRY_W-1:0] diff;
      tbl = 0;
      if (!e[0])
         return 0;
      diff = (e & MASK_4K) - (pool_base_shadow & MASK_4K);
      if ((diff >> PAGE_SHIFT) >= tables_handed_out)
         return -1;
      tbl = int'(diff >> PAGE_SHIFT);
      return 1;
   endfunction

   function automatic status_type apply_map(req_type r);
      int idx [4];
      int tab [4];
      int leaf, known, rc, l, nt;
      logic [ENTRY_W-1:0] e;
      for (l = 0; l < 4; l++) begin
         idx[l] = level_index(r.virt_addr, l);
         tab[l] = 0;
      end
      leaf  = r.huge_page ? 2 : 3;
      known = 0;
      for (l = 0; l < leaf; l++) begin
         e = entry_at(slot_of(tab[l], idx[l]));
         if (l == 2 && e[BIG_POS])
            return ST_UNDER_HUGE;
         rc = follow_pointer(e, tab[l+1]);
         if (rc < 0)
            return ST_EXHAUSTED;
         if (rc == 0)
            break;
         known = l + 1;
      end
      if (leaf - known > TABLE_COUNT - tables_handed_out)
         return ST_EXHAUSTED;
      for (l = known; l < leaf; l++) begin
         nt = tables_handed_out;
         tables_handed_out++;
         table_image[slot_of(tab[l], idx[l])] =
            ((pool_base_shadow & MASK_4K) + (ENTRY_W'(nt) << PAGE_SHIFT)) | PW_BITS;
         tab[l+1] = nt;
      end
      if (r.huge_page)
         e = (r.phys_addr & MASK_2M) | ENTRY_W'(r.entry_flags) | PW_BITS | BIG_BIT;
      else
         e = (r.phys_addr & MASK_4K) | ENTRY_W'(r.entry_flags) | P_BIT;
      table_image[slot_of(tab[leaf], idx[leaf])] = e;
      return ST_OK;
   endfunction

   // walk for translate, or clear the leaf when clear_leaf is set
   function automatic logic [ENTRY_W-1:0] apply_walk(req_type r, bit clear_leaf);
      int idx [4];
      int tab [4];
      int l, slot;
      logic [ENTRY_W-1:0] e;
      for (l = 0; l < 4; l++) begin
         idx[l] = level_index(r.virt_addr, l);
         tab[l] = 0;
      end
      for (l = 0; l < 3; l++) begin
         slot = slot_of(tab[l], idx[l]);
         e    = entry_at(slot);
         if (l == 2 && e[BIG_POS]) begin
            if (clear_leaf) begin
               table_image[slot] = '0;
               return '0;
            end
            return (e & MASK_2M) + ENTRY_W'(r.virt_addr[20:0]);
         end
         if (follow_pointer(e, tab[l+1]) <= 0)
            return '0;
      end
      slot = slot_of(tab[3], idx[3]);
      e    = entry_at(slot);
      if (clear_leaf) begin
         table_image[slot] = '0;
         return '0;
      end
      if (!e[0])
         return '0;
      return (e & MASK_4K) + ENTRY_W'(r.virt_addr[11:0]);
   endfunction

   function automatic rsp_type predict_response(req_type r);
      rsp_type out;
      out = '0;
      case (r.opcode)
         OP_MAP:       out.status = apply_map(r);
         OP_UNMAP:     void'(apply_walk(r, 1'b1));
         OP_TRANSLATE: out.translated_addr = apply_walk(r, 1'b0);
         default:      ;
      endcase
      return out;
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      $display("%0t ns: response %0d: %s", $time, rsp_count, what);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            oldest_rsp = pending_rsp.pop_front();
            if (rsp_data.translated_addr !== oldest_rsp.translated_addr)
               report_mismatch($sformatf("translated_addr %h, expected %h",
                  rsp_data.translated_addr, oldest_rsp.translated_addr));
            if (rsp_data.status !== oldest_rsp.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                  rsp_data.status, oldest_rsp.status));
         end
         rsp_count++;
      end
   end

   // hold start low through the gap, raise it, and wait until busy reads low
   task automatic send_request(req_type r, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      pending_rsp.push_back(predict_response(r));
   endtask

   task automatic send_op(opcode_type op, logic [VIRT_W-1:0] virt, logic [ENTRY_W-1:0] phys,
                          logic [FLAGS_W-1:0] flags, bit huge);
      req_type r;
      r.opcode      = op;
      r.virt_addr   = virt;
      r.phys_addr   = phys;
      r.entry_flags = flags;
      r.huge_page   = huge;
      send_request(r, $urandom_range(0, 5));
   endtask

   task automatic wait_all_responses();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_pool_base(logic [ENTRY_W-1:0] base);
      wait_all_responses();
      repeat (10) @(posedge clock);
      csr_we           <= 1'b1;
      csr_wdata        <= base;
      pool_base_shadow  = base;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [VIRT_W-1:0] random_virt(bit from_history);
      logic [VIRT_W-1:0] v;
      logic [VIRT_W-1:0] seen;
      v = VIRT_W'({$urandom, $urandom});
      if (from_history && mapped_virt.size() > 0) begin
         seen = mapped_virt[$urandom_range(0, mapped_virt.size() - 1)];
         v[VIRT_W-1:21] = seen[VIRT_W-1:21];
         if ($urandom_range(0, 1))
            v[20:12] = seen[20:12];
      end else if ($urandom_range(0, 9) != 0) begin
         v[47:39] = top_pick[$urandom_range(0, 1)];
         v[38:30] = mid_pick[$urandom_range(0, 1)];
         v[29:21] = dir_pick[$urandom_range(0, 3)];
      end
      return v;
   endfunction

   task automatic test_directed_map_walks();
      write_pool_base('0);
      send_op(OP_TRANSLATE, VA_LOW, '0, '0, 1'b0);
      send_op(OP_UNMAP, VA_HIGH, '0, '0, 1'b0);
      send_op(OP_NONE, VA_HIGH, PA_HIGH, '1, 1'b1);
      send_op(OP_MAP, VA_LOW, PA_HIGH, 12'hFFF, 1'b0);
      send_op(OP_TRANSLATE, VA_LOW | 48'hFFF, '0, '0, 1'b0);
      send_op(OP_MAP, VA_HIGH, '0, '0, 1'b0);
      send_op(OP_TRANSLATE, VA_HIGH, '0, '0, 1'b0);
      send_op(OP_MAP, VA_HUGE, PA_HIGH, '0, 1'b1);
      send_op(OP_TRANSLATE, VA_HUGE | 48'h1F_FFFF, '0, '0, 1'b0);
      send_op(OP_MAP, VA_HUGE | 48'h5000, 52'h1234_5000, 12'h003, 1'b0);
      send_op(OP_MAP, VA_LOW, 52'hA_BCDE_F012_3456, 12'h800, 1'b1);
      send_op(OP_TRANSLATE, VA_LOW | 48'h1234, '0, '0, 1'b0);
      send_op(OP_UNMAP, VA_LOW, '0, '0, 1'b0);
      send_op(OP_TRANSLATE, VA_LOW, '0, '0, 1'b0);
      send_op(OP_MAP, VA_LOW, 52'h5_5555_5555_5555, 12'h0AA, 1'b0);
      send_op(OP_MAP, VA_LOW, 52'hA_AAAA_AAAA_AAAA, 12'h555, 1'b0);
      send_op(OP_TRANSLATE, VA_LOW | 48'h7FF, '0, '0, 1'b0);
      send_op(OP_UNMAP, VA_HIGH, '0, '0, 1'b0);
      send_op(OP_TRANSLATE, VA_HIGH, '0, '0, 1'b0);
      send_op(OP_UNMAP, VA_HUGE, '0, '0, 1'b0);
      send_op(OP_TRANSLATE, VA_HUGE, '0, '0, 1'b0);
      send_op(OP_MAP, VA_HIGH, PA_HIGH, 12'hFFF, 1'b1);
      send_op(OP_TRANSLATE, VA_HIGH, '0, '0, 1'b0);
      mapped_virt.push_back(VA_LOW);
      mapped_virt.push_back(VA_HIGH);
   endtask

   // move the pool so existing pointers decode to other tables or fall outside it
   task automatic test_pool_relocation();
      write_pool_base(52'h0_0000_0000_1ABC);
      send_op(OP_TRANSLATE, VA_HIGH, '0, '0, 1'b0);
      send_op(OP_TRANSLATE, VA_LOW, '0, '0, 1'b0);
      send_op(OP_MAP, VA_LOW | 48'h3000, 52'h7_0000_1000, 12'h001, 1'b0);
      send_op(OP_UNMAP, VA_HUGE, '0, '0, 1'b0);
      send_op(OP_MAP, 48'h8000_0000_0000, 52'h9_8765_4000, 12'h010, 1'b0);
      send_op(OP_TRANSLATE, 48'h8000_0000_0ABC, '0, '0, 1'b0);
   endtask

   task automatic test_random_traffic(logic [ENTRY_W-1:0] base, int count);
      req_type r;
      int      pick;
      bit      no_idle;
      write_pool_base(base);
      foreach (top_pick[k]) top_pick[k] = IDX_W'($urandom);
      foreach (mid_pick[k]) mid_pick[k] = IDX_W'($urandom);
      foreach (dir_pick[k]) dir_pick[k] = IDX_W'($urandom);
      no_idle = 1'b0;
      for (int n = 0; n < count; n++) begin
         if (n % 16 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 39) == 0)
            wait_all_responses();
         pick = $urandom_range(0, 99);
         if (pick < 40)
            r.opcode = OP_MAP;
         else if (pick < 55)
            r.opcode = OP_UNMAP;
         else if (pick < 95)
            r.opcode = OP_TRANSLATE;
         else
            r.opcode = OP_NONE;
         r.virt_addr   = random_virt(r.opcode == OP_MAP ? ($urandom_range(0, 9) < 3)
                                                         : ($urandom_range(0, 9) < 6));
         r.phys_addr   = ENTRY_W'({$urandom, $urandom});
         r.entry_flags = FLAGS_W'($urandom);
         r.huge_page   = ($urandom_range(0, 3) == 0);
         if (r.opcode == OP_MAP) begin
            mapped_virt.push_back(r.virt_addr);
            if (mapped_virt.size() > 64)
               void'(mapped_virt.pop_front());
         end
         send_request(r, no_idle ? 0 : int'($urandom_range(0, 5)));
      end
   endtask

   task automatic test_pool_exhaustion();
      logic [VIRT_W-1:0] v;
      int                guard;
      guard = 0;
      while (TABLE_COUNT - tables_handed_out >= 3 && guard < 300) begin
         v = VIRT_W'({$urandom, $urandom});
         send_op(OP_MAP, v, ENTRY_W'({$urandom, $urandom}), FLAGS_W'($urandom), 1'b0);
         mapped_virt.push_back(v);
         guard++;
      end
      repeat (3) send_op(OP_MAP, VIRT_W'({$urandom, $urandom}),
                         ENTRY_W'({$urandom, $urandom}), '0, 1'b0);
      repeat (8) begin
         v = random_virt(1'b1);
         v[29:21] = IDX_W'($urandom);
         send_op(OP_MAP, v, ENTRY_W'({$urandom, $urandom}), FLAGS_W'($urandom),
                 1'($urandom_range(0, 1)));
         send_op(OP_TRANSLATE, v, '0, '0, 1'b0);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_map_walks();
      test_pool_relocation();
      test_random_traffic('0, 160);
      test_random_traffic('1, 160);
      test_random_traffic(ENTRY_W'({$urandom, $urandom}), 160);
      test_pool_exhaustion();
      wait_all_responses();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("[four_level_page_table_manager_top] OK");
      else
         $display("[four_level_page_table_manager_top] ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[four_level_page_table_manager_top] ERROR");
      $finish;
   end

endmodule
